>>> design/dhcp6p_pkg.sv
// types and constants shared by the dhcpv6 option parser
package dhcp6p_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [2:0]  record_index;
    logic [63:0] record_value;
    logic [1:0]  end_status;
    logic        run_last;
  } out_rec_t;

  // record kinds
  localparam logic [3:0] K_HEADER  = 4'd0;
  localparam logic [3:0] K_CLIENT  = 4'd1;
  localparam logic [3:0] K_SERVER  = 4'd2;
  localparam logic [3:0] K_NA_IAID = 4'd3;
  localparam logic [3:0] K_ADDR    = 4'd4;
  localparam logic [3:0] K_PD_IAID = 4'd5;
  localparam logic [3:0] K_PFX_LEN = 4'd6;
  localparam logic [3:0] K_PFX     = 4'd7;
  localparam logic [3:0] K_DNS     = 4'd8;
  localparam logic [3:0] K_DNS_CNT = 4'd9;
  localparam logic [3:0] K_SEARCH  = 4'd10;
  localparam logic [3:0] K_SNTP    = 4'd11;
  localparam logic [3:0] K_SNTP_CNT = 4'd12;
  localparam logic [3:0] K_REFRESH = 4'd13;
  localparam logic [3:0] K_END     = 4'd14;

  // end status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // option codes
  localparam logic [15:0] C_CLIENT   = 16'd1;
  localparam logic [15:0] C_SERVER   = 16'd2;
  localparam logic [15:0] C_IANA     = 16'd3;
  localparam logic [15:0] C_IAADDR   = 16'd5;
  localparam logic [15:0] C_DNS      = 16'd23;
  localparam logic [15:0] C_SEARCH   = 16'd24;
  localparam logic [15:0] C_IAPD     = 16'd25;
  localparam logic [15:0] C_IAPREFIX = 16'd26;
  localparam logic [15:0] C_SNTP     = 16'd31;
  localparam logic [15:0] C_REFRESH  = 16'd32;

  // parse phases
  localparam logic [3:0] PH_HDR   = 4'd0;
  localparam logic [3:0] PH_OHDR  = 4'd1;
  localparam logic [3:0] PH_OVAL  = 4'd2;
  localparam logic [3:0] PH_IHDR  = 4'd3;
  localparam logic [3:0] PH_IVAL  = 4'd4;
  localparam logic [3:0] PH_ISKIP = 4'd5;

  localparam logic [15:0] HDR_BYTES  = 16'd4;
  localparam logic [15:0] IA_FIXED   = 16'd12;
  localparam logic [15:0] ADDR_BYTES = 16'd16;
  localparam logic [15:0] PREFIX_MIN = 16'd25;
  localparam logic [15:0] PREFIX_AT  = 16'd9;

endpackage

>>> design/dhcpv6_option_parser.sv
// dhcpv6 option parser top level: byte-wise option walker and record queue
// Takes one message byte per cycle while in_stall is low and emits zero, one
// or two records per byte. Parsing is combinational; the records go into a
// four-entry queue that drains one record per cycle while out_stall is low,
// so the sustained rate is one byte per cycle while each byte yields at most
// one record; in_stall rises when the queue has fewer than two free entries.
module dhcpv6_option_parser #(
  parameter int MAX_DNS_SERVERS  = 4,
  parameter int MAX_SNTP_SERVERS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dhcp6p_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dhcp6p_pkg::out_rec_t  out_rec
);
  import dhcp6p_pkg::*;

  localparam logic [11:0] MAX_DNS  = 12'(MAX_DNS_SERVERS);
  localparam logic [11:0] MAX_SNTP = 12'(MAX_SNTP_SERVERS);

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] outer_code_r, outer_code_nxt;
  logic [15:0] outer_len_r, outer_len_nxt;
  logic [15:0] outer_count_r, outer_count_nxt;
  logic [15:0] inner_code_r, inner_code_nxt;
  logic [15:0] inner_len_r, inner_len_nxt;
  logic [15:0] inner_count_r, inner_count_nxt;
  logic [63:0] word_r, word_nxt;
  logic        stopped_r, stopped_nxt;

  out_rec_t    q_mem [4];
  logic [1:0]  q_wr_r, q_rd_r;
  logic [2:0]  q_cnt_r;

  logic        accept, pop;
  logic        prec_v;
  out_rec_t    prec, erec, rec0, rec1;
  logic [1:0]  nrec;

  logic [15:0] pos, flen, i, ic1, oc1, len_new, ilen_new;
  logic [17:0] reach;
  logic [11:0] cnt, srv;
  logic [3:0]  b;
  logic [2:0]  widx;
  logic        srv_ok;
  logic [15:0] bo_sat;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  always_comb begin
    prec_v          = 1'b0;
    prec            = '0;
    erec            = '0;
    byte_offset_nxt = byte_offset_r;
    frame_len_nxt   = frame_len_r;
    phase_nxt       = phase_r;
    outer_code_nxt  = outer_code_r;
    outer_len_nxt   = outer_len_r;
    outer_count_nxt = outer_count_r;
    inner_code_nxt  = inner_code_r;
    inner_len_nxt   = inner_len_r;
    inner_count_nxt = inner_count_r;
    stopped_nxt     = stopped_r;
    pos      = byte_offset_r;
    flen     = (pos == 16'd0) ? in_item.frame_length : frame_len_r;
    frame_len_nxt = flen;
    word_nxt = {word_r[55:0], in_item.data_byte};
    i        = outer_count_r;
    oc1      = outer_count_r + 16'd1;
    ic1      = inner_count_r + 16'd1;
    len_new  = word_nxt[15:0];
    ilen_new = word_nxt[15:0];
    reach    = 18'(pos) + 18'd1 + 18'(len_new);
    cnt      = len_new[15:4];
    srv      = i[15:4];
    b        = i[3:0];
    widx     = {srv[1:0], (b == 4'd15)};
    srv_ok   = (outer_len_r != 16'd0) && (outer_len_r[3:0] == 4'd0);

    if (!stopped_r && pos < flen) begin
      if (phase_r == PH_HDR) begin
        if (pos == HDR_BYTES - 16'd1) begin
          prec_v = 1'b1;
          prec.record_kind  = K_HEADER;
          prec.record_value = {32'd0, word_nxt[31:0]};
          phase_nxt = PH_OHDR;
          outer_count_nxt = '0;
        end
      end else if (phase_r == PH_OHDR) begin
        if (oc1 < HDR_BYTES) begin
          outer_count_nxt = oc1;
        end else begin
          outer_code_nxt  = word_nxt[31:16];
          outer_len_nxt   = len_new;
          outer_count_nxt = '0;
          if (reach > 18'(flen)) begin
            stopped_nxt = 1'b1;
          end else begin
            prec.record_value = {32'd0, pos + 16'd1, len_new};
            priority if (word_nxt[31:16] == C_CLIENT) begin
              prec_v = 1'b1;
              prec.record_kind = K_CLIENT;
            end else if (word_nxt[31:16] == C_SERVER) begin
              prec_v = 1'b1;
              prec.record_kind = K_SERVER;
            end else if (word_nxt[31:16] == C_SEARCH && len_new != 16'd0) begin
              prec_v = 1'b1;
              prec.record_kind = K_SEARCH;
            end else if (word_nxt[31:16] == C_DNS && len_new != 16'd0
                         && len_new[3:0] == 4'd0) begin
              prec_v = 1'b1;
              prec.record_kind  = K_DNS_CNT;
              prec.record_value = 64'((cnt > MAX_DNS) ? MAX_DNS : cnt);
            end else if (word_nxt[31:16] == C_SNTP && len_new != 16'd0
                         && len_new[3:0] == 4'd0) begin
              prec_v = 1'b1;
              prec.record_kind  = K_SNTP_CNT;
              prec.record_value = 64'((cnt > MAX_SNTP) ? MAX_SNTP : cnt);
            end
            phase_nxt = (len_new == 16'd0) ? PH_OHDR : PH_OVAL;
          end
        end
      end else begin
        if (phase_r == PH_OVAL) begin
          priority if ((outer_code_r == C_IANA || outer_code_r == C_IAPD)
                       && outer_len_r >= IA_FIXED) begin
            if (i == 16'd3) begin
              prec_v = 1'b1;
              prec.record_kind  = (outer_code_r == C_IANA) ? K_NA_IAID : K_PD_IAID;
              prec.record_value = {32'd0, word_nxt[31:0]};
            end
            if (i == IA_FIXED - 16'd1) begin
              phase_nxt = PH_IHDR;
              inner_count_nxt = '0;
            end
          end else if (outer_code_r == C_DNS && srv_ok) begin
            if (srv < MAX_DNS && (b == 4'd7 || b == 4'd15)) begin
              prec_v = 1'b1;
              prec.record_kind  = K_DNS;
              prec.record_index = widx;
              prec.record_value = word_nxt;
            end
          end else if (outer_code_r == C_SNTP && srv_ok) begin
            if (srv < MAX_SNTP && (b == 4'd7 || b == 4'd15)) begin
              prec_v = 1'b1;
              prec.record_kind  = K_SNTP;
              prec.record_index = widx;
              prec.record_value = word_nxt;
            end
          end else if (outer_code_r == C_REFRESH && outer_len_r >= HDR_BYTES
                       && i == 16'd3) begin
            prec_v = 1'b1;
            prec.record_kind  = K_REFRESH;
            prec.record_value = {32'd0, word_nxt[31:0]};
          end
        end else if (phase_r == PH_IHDR) begin
          inner_count_nxt = ic1;
          if (ic1 >= HDR_BYTES) begin
            inner_code_nxt  = word_nxt[31:16];
            inner_len_nxt   = ilen_new;
            inner_count_nxt = '0;
            if (17'(i) + 17'd1 + 17'(ilen_new) > 17'(outer_len_r)) begin
              phase_nxt = PH_ISKIP;
            end else if (ilen_new != 16'd0) begin
              phase_nxt = PH_IVAL;
            end
          end
        end else if (phase_r == PH_IVAL) begin
          priority if (outer_code_r == C_IANA && inner_code_r == C_IAADDR
                       && inner_len_r >= ADDR_BYTES) begin
            if (inner_count_r == 16'd7 || inner_count_r == 16'd15) begin
              prec_v = 1'b1;
              prec.record_kind  = K_ADDR;
              prec.record_index = {2'b00, (inner_count_r == 16'd15)};
              prec.record_value = word_nxt;
            end
          end else if (outer_code_r == C_IAPD && inner_code_r == C_IAPREFIX
                       && inner_len_r >= PREFIX_MIN) begin
            if (inner_count_r == PREFIX_AT - 16'd1) begin
              prec_v = 1'b1;
              prec.record_kind  = K_PFX_LEN;
              prec.record_value = {56'd0, in_item.data_byte};
            end else if (inner_count_r == PREFIX_AT + 16'd7
                         || inner_count_r == PREFIX_AT + 16'd15) begin
              prec_v = 1'b1;
              prec.record_kind  = K_PFX;
              prec.record_index = {2'b00, (inner_count_r == PREFIX_AT + 16'd15)};
              prec.record_value = word_nxt;
            end
          end
          inner_count_nxt = ic1;
          if (ic1 >= inner_len_r) begin
            phase_nxt = PH_IHDR;
            inner_count_nxt = '0;
          end
        end
        outer_count_nxt = oc1;
        if (oc1 >= outer_len_r) begin
          phase_nxt       = PH_OHDR;
          outer_count_nxt = '0;
          inner_count_nxt = '0;
        end
      end
    end

    bo_sat = (byte_offset_r != 16'hFFFF) ? byte_offset_r + 16'd1 : byte_offset_r;
    byte_offset_nxt = bo_sat;
    erec.record_kind  = K_END;
    erec.record_value = {48'd0, bo_sat};
    erec.run_last     = 1'b1;
    if (bo_sat < HDR_BYTES || flen < HDR_BYTES) begin
      erec.end_status = ST_SHORT;
    end else if (bo_sat != flen) begin
      erec.end_status = ST_MISMATCH;
    end else begin
      erec.end_status = ST_OK;
    end

    // end of message: back to the reset state
    if (in_item.last_byte) begin
      byte_offset_nxt = '0;
      frame_len_nxt   = '0;
      phase_nxt       = PH_HDR;
      outer_code_nxt  = '0;
      outer_len_nxt   = '0;
      outer_count_nxt = '0;
      inner_code_nxt  = '0;
      inner_len_nxt   = '0;
      inner_count_nxt = '0;
      word_nxt        = '0;
      stopped_nxt     = 1'b0;
    end

    rec0 = prec;
    rec1 = erec;
    nrec = 2'd0;
    if (prec_v && in_item.last_byte) begin
      nrec = 2'd2;
    end else if (prec_v) begin
      rec0.run_last = 1'b1;
      nrec = 2'd1;
    end else if (in_item.last_byte) begin
      rec0 = erec;
      nrec = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      frame_len_r   <= '0;
      phase_r       <= PH_HDR;
      outer_code_r  <= '0;
      outer_len_r   <= '0;
      outer_count_r <= '0;
      inner_code_r  <= '0;
      inner_len_r   <= '0;
      inner_count_r <= '0;
      word_r        <= '0;
      stopped_r     <= 1'b0;
    end else if (accept) begin
      byte_offset_r <= byte_offset_nxt;
      frame_len_r   <= frame_len_nxt;
      phase_r       <= phase_nxt;
      outer_code_r  <= outer_code_nxt;
      outer_len_r   <= outer_len_nxt;
      outer_count_r <= outer_count_nxt;
      inner_code_r  <= inner_code_nxt;
      inner_len_r   <= inner_len_nxt;
      inner_count_r <= inner_count_nxt;
      word_r        <= word_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

  // record queue
  always_ff @(posedge clk) begin
    if (accept && nrec != 2'd0) begin
      q_mem[q_wr_r] <= rec0;
    end
    if (accept && nrec == 2'd2) begin
      q_mem[q_wr_r + 2'd1] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (accept) begin
        q_wr_r <= q_wr_r + nrec;
      end
      if (pop) begin
        q_rd_r <= q_rd_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + (accept ? {1'b0, nrec} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  assign in_stall  = (q_cnt_r > 3'd2);
  assign out_valid = (q_cnt_r != 3'd0);
  assign out_rec   = q_mem[q_rd_r];

endmodule

>>> bench/dhcp6p_checker.sv
// checker for the dhcpv6 option parser: predicts records and compares them
module dhcp6p_checker
  import dhcp6p_pkg::*;
#(
  parameter int MAX_DNS_SERVERS  = 4,
  parameter int MAX_SNTP_SERVERS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_item_t in_item,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_rec_t out_rec,
  output int       fail_count,
  output int       records_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] pos_q, flen_q, ocode, olen, ocnt, icode, ilen, icnt;
  logic [3:0]  phase;
  logic [63:0] shreg;
  logic        halted;
  out_rec_t    rec_q[$];
  out_rec_t    step_recs[$];

  assign records_pending = rec_q.size();

  task automatic report(input string what, input out_rec_t got, input out_rec_t want);
    $display("mismatch %s: got k%0d i%0d v%h s%0d l%0d want k%0d i%0d v%h s%0d l%0d",
             what, got.record_kind, got.record_index, got.record_value, got.end_status,
             got.run_last, want.record_kind, want.record_index, want.record_value,
             want.end_status, want.run_last);
    fail_count++;
  endtask

  function automatic void add_rec(logic [3:0] k, int idx, logic [63:0] v, logic [1:0] st);
    out_rec_t r;
    if (step_recs.size() >= 2) return;
    r.record_kind = k;
    r.record_index = idx[2:0];
    r.record_value = v;
    r.end_status = st;
    r.run_last = 1'b0;
    step_recs.push_back(r);
  endfunction

  function automatic void clear_state();
    pos_q = 0; flen_q = 0; phase = PH_HDR; ocode = 0; olen = 0; ocnt = 0;
    icode = 0; ilen = 0; icnt = 0; shreg = 0; halted = 0;
  endfunction

  function automatic bit servers_ok(logic [15:0] len);
    return len != 0 && len[3:0] == 0;
  endfunction

  function automatic void option_header_done(int vstart);
    logic [63:0] loc;
    int cnt;
    loc = {32'd0, vstart[15:0], olen};
    cnt = olen / 16;
    if (ocode == C_CLIENT) add_rec(K_CLIENT, 0, loc, ST_OK);
    else if (ocode == C_SERVER) add_rec(K_SERVER, 0, loc, ST_OK);
    else if (ocode == C_SEARCH && olen > 0) add_rec(K_SEARCH, 0, loc, ST_OK);
    else if (ocode == C_DNS && servers_ok(olen))
      add_rec(K_DNS_CNT, 0, (cnt > MAX_DNS_SERVERS) ? MAX_DNS_SERVERS : cnt, ST_OK);
    else if (ocode == C_SNTP && servers_ok(olen))
      add_rec(K_SNTP_CNT, 0, (cnt > MAX_SNTP_SERVERS) ? MAX_SNTP_SERVERS : cnt, ST_OK);
  endfunction

  function automatic void plain_value(int i);
    int srv, b, widx;
    srv = i / 16;
    b = i % 16;
    widx = srv * 2 + ((b == 15) ? 1 : 0);
    if ((ocode == C_IANA || ocode == C_IAPD) && olen >= IA_FIXED) begin
      if (i == 3) add_rec((ocode == C_IANA) ? K_NA_IAID : K_PD_IAID, 0, shreg[31:0], ST_OK);
      if (i == IA_FIXED - 1) begin
        phase = PH_IHDR;
        icnt = 0;
      end
    end else if (ocode == C_DNS && servers_ok(olen)) begin
      if (srv < MAX_DNS_SERVERS && (b == 7 || b == 15)) add_rec(K_DNS, widx, shreg, ST_OK);
    end else if (ocode == C_SNTP && servers_ok(olen)) begin
      if (srv < MAX_SNTP_SERVERS && (b == 7 || b == 15)) add_rec(K_SNTP, widx, shreg, ST_OK);
    end else if (ocode == C_REFRESH && olen >= 4 && i == 3) begin
      add_rec(K_REFRESH, 0, shreg[31:0], ST_OK);
    end
  endfunction

  function automatic void inner_value(logic [7:0] byt);
    if (ocode == C_IANA && icode == C_IAADDR && ilen >= ADDR_BYTES) begin
      if (icnt == 7) add_rec(K_ADDR, 0, shreg, ST_OK);
      else if (icnt == 15) add_rec(K_ADDR, 1, shreg, ST_OK);
    end else if (ocode == C_IAPD && icode == C_IAPREFIX && ilen >= PREFIX_MIN) begin
      if (icnt == PREFIX_AT - 1) add_rec(K_PFX_LEN, 0, byt, ST_OK);
      else if (icnt == PREFIX_AT + 7) add_rec(K_PFX, 0, shreg, ST_OK);
      else if (icnt == PREFIX_AT + 15) add_rec(K_PFX, 1, shreg, ST_OK);
    end
  endfunction

  function automatic void walk_byte(int pos, logic [7:0] byt);
    int i;
    if (phase == PH_HDR) begin
      if (pos == HDR_BYTES - 1) begin
        add_rec(K_HEADER, 0, shreg[31:0], ST_OK);
        phase = PH_OHDR;
        ocnt = 0;
      end
      return;
    end
    if (phase == PH_OHDR) begin
      ocnt++;
      if (ocnt < HDR_BYTES) return;
      ocode = shreg[31:16];
      olen = shreg[15:0];
      ocnt = 0;
      if (pos + 1 + int'(olen) > int'(flen_q)) begin
        halted = 1;
        return;
      end
      option_header_done(pos + 1);
      phase = (olen == 0) ? PH_OHDR : PH_OVAL;
      return;
    end
    i = ocnt;
    if (phase == PH_OVAL) begin
      plain_value(i);
    end else if (phase == PH_IHDR) begin
      icnt++;
      if (icnt >= HDR_BYTES) begin
        icode = shreg[31:16];
        ilen = shreg[15:0];
        icnt = 0;
        if (i + 1 + int'(ilen) > int'(olen)) phase = PH_ISKIP;
        else if (ilen != 0) phase = PH_IVAL;
      end
    end else if (phase == PH_IVAL) begin
      inner_value(byt);
      icnt++;
      if (icnt >= ilen) begin
        phase = PH_IHDR;
        icnt = 0;
      end
    end
    ocnt++;
    if (ocnt >= olen) begin
      phase = PH_OHDR;
      ocnt = 0;
      icnt = 0;
    end
  endfunction

  function automatic void predict_request(in_item_t it);
    int pos;
    logic [1:0] st;
    step_recs.delete();
    pos = pos_q;
    if (pos == 0) flen_q = it.frame_length;
    shreg = {shreg[55:0], it.data_byte};
    if (!halted && pos < flen_q) walk_byte(pos, it.data_byte);
    if (pos_q != 16'hFFFF) pos_q++;
    if (it.last_byte) begin
      st = ST_OK;
      if (pos_q < HDR_BYTES || flen_q < HDR_BYTES) st = ST_SHORT;
      else if (pos_q != flen_q) st = ST_MISMATCH;
      add_rec(K_END, 0, pos_q, st);
      clear_state();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].run_last = 1'b1;
    foreach (step_recs[k]) rec_q.push_back(step_recs[k]);
  endfunction

  initial begin
    fail_count = 0;
    clear_state();
  end

  always @(posedge clk) begin
    out_rec_t want;
    if (!rst_n) begin
      clear_state();
      rec_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (rec_q.size() == 0) begin
          report("unexpected record", out_rec, out_rec);
        end else begin
          want = rec_q.pop_front();
          if (out_rec.record_kind !== want.record_kind) report("kind", out_rec, want);
          if (out_rec.record_index !== want.record_index) report("index", out_rec, want);
          if (out_rec.record_value !== want.record_value) report("value", out_rec, want);
          if (out_rec.end_status !== want.end_status) report("status", out_rec, want);
          if (out_rec.run_last !== want.run_last) report("run_last", out_rec, want);
        end
      end
      if (in_valid && !in_stall) predict_request(in_item);
    end
  end
endmodule

>>> bench/tb_dhcpv6_option_parser.sv
// top of the dhcpv6 option parser testbench: stimulus and verdict
module tb_dhcpv6_option_parser;
  import dhcp6p_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_item_t in_item;
  out_rec_t out_rec;
  int       fail_count, records_pending, cycle_count, sent;
  bit       hold_off, long_done;
  logic [7:0] msg[$];

  dhcpv6_option_parser dut (.*);
  dhcp6p_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("tb_dhcpv6_option_parser: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stall pattern plus one long hold-off
  initial begin
    int mode;
    out_stall = 0;
    hold_off = 0;
    long_done = 0;
    forever begin
      @(posedge clk);
      if (!long_done && sent > 300) begin
        long_done = 1;
        hold_off = 1;
        out_stall <= 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      mode = (cycle_count / 500) % 3;
      if (mode == 0) out_stall <= 0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  task automatic push16(int v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endtask

  task automatic push_rand(int n);
    repeat (n) msg.push_back($urandom_range(0, 255));
  endtask

  task automatic push_opt(int code);
    int len, n;
    case (code)
      C_CLIENT, C_SERVER, C_SEARCH: len = $urandom_range(0, 10);
      C_DNS, C_SNTP: begin
        n = $urandom_range(0, 6);
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : n * 16;
      end
      C_REFRESH: len = $urandom_range(0, 5);
      C_IANA: begin
        len = 12 + 4 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 24);
      end
      C_IAPD: len = 12 + 4 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : 25);
      default: len = $urandom_range(0, 6);
    endcase
    push16(code);
    push16(len);
    if (code == C_IANA || code == C_IAPD) begin
      push_rand(12);
      push16((code == C_IANA) ? C_IAADDR : C_IAPREFIX);
      // inner length sometimes overruns the enclosing option
      push16(($urandom_range(0, 4) == 0) ? len : len - 16);
      push_rand(len - 16);
    end else begin
      push_rand(len);
    end
  endtask

  // build a message; kind picks well-formed, bad length, or noise
  task automatic build_msg(int kind);
    int nopt;
    int codes[10] = '{C_CLIENT, C_SERVER, C_IANA, C_DNS, C_SEARCH, C_IAPD,
                      C_SNTP, C_REFRESH, 16'd7, 16'hFFFF};
    msg.delete();
    push_rand(4);
    nopt = $urandom_range(1, 4);
    repeat (nopt) push_opt(codes[$urandom_range(0, 9)]);
    if (kind == 1) push_rand($urandom_range(1, 3));
    if (kind == 2) begin
      msg.delete();
      push_rand($urandom_range(1, 40));
    end
  endtask

  task automatic send_msg(int flen, bit cut);
    int n;
    n = msg.size();
    if (cut && n > 1) n = $urandom_range(1, n - 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_valid <= 1;
      in_item.data_byte <= msg[k];
      in_item.frame_length <= ((k == 0) || $urandom_range(0, 1)) ? flen[15:0]
                                                                  : 16'($urandom);
      in_item.last_byte <= (k == n - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sent++;
    end
  endtask

  initial begin
    int r;
    sent = 0;
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: short frames, exact-length options, extremes
    msg = '{8'hFF, 8'h00, 8'hFF, 8'h00};
    send_msg(4, 0);
    msg = '{8'h01, 8'h02};
    send_msg(2, 0);
    msg = '{8'h01};
    send_msg(65535, 0);
    msg = '{8'h0B, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h20, 8'h00, 8'h04,
            8'h12, 8'h34, 8'h56, 8'h78};
    send_msg(12, 0);
    msg = '{8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h18, 8'h00, 8'h00,
            8'h00, 8'h01, 8'h00, 8'h09, 8'h00};
    send_msg(13, 0);
    while (sent < 850) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        build_msg(0);
        send_msg(msg.size(), 0);
      end else if (r < 8) begin
        build_msg(1);
        send_msg(msg.size() - $urandom_range(0, 2), 0);
      end else if (r == 8) begin
        build_msg(0);
        send_msg($urandom_range(1, 65535), $urandom_range(0, 1));
      end else begin
        build_msg(2);
        send_msg($urandom_range(1, 8), 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_valid <= 0;
    while (records_pending != 0 || hold_off) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb_dhcpv6_option_parser: done, clean");
    else $display("tb_dhcpv6_option_parser: done, errors");
    $finish;
  end
endmodule

>>> files.f
design/dhcp6p_pkg.sv
design/dhcpv6_option_parser.sv
bench/dhcp6p_checker.sv
bench/tb_dhcpv6_option_parser.sv
